@@ rtl/pfm_pkg.sv @@
// Shared constants, request and result types, and chain tokens for the frame map.
`default_nettype none

package pfm_pkg;

	// Table and field geometry
	localparam int INDEX_BITS = 24;
	localparam int SPEED_W    = 24;
	localparam int MAX_CUTS   = 16;
	localparam int MAX_RAMPS  = 16;
	localparam int SLOT_W     = 4;
	localparam int OP_W       = 2;
	localparam int FC_W       = 25;
	localparam int CNT_W      = 5;
	localparam int CFG_IDX_W  = 2;
	localparam int FRAC_BITS  = 12;

	// Rate arithmetic widths
	localparam int PROD_W = INDEX_BITS + SPEED_W;
	localparam int Q_W    = PROD_W + 1 - FRAC_BITS;
	localparam int SUM_W  = Q_W + 2;

	localparam logic [SPEED_W-1:0]  UNIT_RATE  = SPEED_W'(1 << FRAC_BITS);
	localparam logic [PROD_W:0]     ROUND_HALF = (PROD_W+1)'(1 << (FRAC_BITS - 1));

	// Request opcodes
	localparam logic [OP_W-1:0] OP_QUERY = 2'd0;
	localparam logic [OP_W-1:0] OP_CUT   = 2'd1;
	localparam logic [OP_W-1:0] OP_RAMP  = 2'd2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CUT_ENTRIES  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RAMP_ENTRIES = 2'd2;

	typedef struct packed {
		logic [OP_W-1:0]           opcode;
		logic [SLOT_W-1:0]         entry_slot;
		logic [INDEX_BITS-1:0]     range_first;
		logic [INDEX_BITS-1:0]     range_after;
		logic signed [SPEED_W-1:0] ramp_speed;
		logic [INDEX_BITS-1:0]     playback_index;
	} request_t;

	typedef struct packed {
		logic [INDEX_BITS-1:0] source_index;
		logic                  ramp_applied;
		logic                  range_clamped;
	} result_t;

	// Table entry write, shared by cut and ramp cells
	typedef struct packed {
		logic [INDEX_BITS-1:0] first;
		logic [INDEX_BITS-1:0] after;
		logic [SPEED_W-1:0]    speed;
	} ent_wr_t;

	// Token travelling along the ramp cells
	typedef struct packed {
		logic                  vld;
		logic                  live;
		logic                  hit;
		logic [INDEX_BITS-1:0] p;
		logic [INDEX_BITS-1:0] rf;
		logic [SPEED_W-1:0]    rs;
	} ramp_tok_t;

	// Token travelling along the cut cells
	typedef struct packed {
		logic                  vld;
		logic                  live;
		logic                  sat;
		logic                  hit;
		logic [INDEX_BITS-1:0] src;
		logic [INDEX_BITS-1:0] delta;
		logic [SPEED_W-1:0]    rs;
	} cut_tok_t;

endpackage

`default_nettype wire

@@ rtl/pfm_ramp_cell.sv @@
// One speed ramp cell: holds a ramp entry and tests the passing query token against it.
`default_nettype none

module pfm_ramp_cell (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              wr_en,
	input  wire pfm_pkg::ent_wr_t  wr_entry,
	input  wire logic              entry_on,
	input  wire pfm_pkg::ramp_tok_t tok_in,
	output pfm_pkg::ramp_tok_t     tok_q
);

	logic [pfm_pkg::INDEX_BITS-1:0] first_q;
	logic [pfm_pkg::INDEX_BITS-1:0] after_q;
	logic [pfm_pkg::SPEED_W-1:0]    speed_q;
	pfm_pkg::ramp_tok_t             tok_d;

	// Hold the ramp entry
	always_ff @(posedge clk) begin
		if (wr_en) begin
			first_q <= wr_entry.first;
			after_q <= wr_entry.after;
			speed_q <= wr_entry.speed;
		end
	end

	// Stop the scan before the ramp, or inside it; take the ramp when its rate is not unity
	always_comb begin
		tok_d = tok_in;
		if (tok_in.vld && tok_in.live && entry_on) begin
			if (tok_in.p < first_q) begin
				tok_d.live = 1'b0;
			end else if (tok_in.p < after_q) begin
				tok_d.live = 1'b0;
				if (speed_q != pfm_pkg::UNIT_RATE) begin
					tok_d.hit = 1'b1;
					tok_d.rf  = first_q;
					tok_d.rs  = speed_q;
				end
			end
		end
	end

	// Hand the token to the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_d;
		end
	end

endmodule

`default_nettype wire

@@ rtl/pfm_cut_cell.sv @@
// One cut cell: holds a cut entry and adds its length to the passing source index.
`default_nettype none

module pfm_cut_cell (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              wr_en,
	input  wire pfm_pkg::ent_wr_t  wr_entry,
	input  wire logic              entry_on,
	input  wire pfm_pkg::cut_tok_t tok_in,
	output pfm_pkg::cut_tok_t      tok_q
);

	logic [pfm_pkg::INDEX_BITS-1:0] first_q;
	logic [pfm_pkg::INDEX_BITS-1:0] len_q;
	logic [pfm_pkg::INDEX_BITS:0]   sum;
	pfm_pkg::cut_tok_t              tok_d;

	// Hold the cut start and its length; a reversed range has no length
	always_ff @(posedge clk) begin
		if (wr_en) begin
			first_q <= wr_entry.first;
			len_q   <= (wr_entry.after > wr_entry.first) ?
				(wr_entry.after - wr_entry.first) : '0;
		end
	end

	assign sum = {1'b0, tok_in.src} + {1'b0, len_q};

	// Stop at the first cut not yet reached; otherwise add its length, saturating
	always_comb begin
		tok_d = tok_in;
		if (tok_in.vld && tok_in.live && entry_on) begin
			if (tok_in.src < first_q) begin
				tok_d.live = 1'b0;
			end else if (sum[pfm_pkg::INDEX_BITS]) begin
				tok_d.src = '1;
				tok_d.sat = 1'b1;
			end else begin
				tok_d.src = sum[pfm_pkg::INDEX_BITS-1:0];
			end
		end
	end

	// Hand the token to the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_d;
		end
	end

endmodule

`default_nettype wire

@@ rtl/pfm_scale.sv @@
// Ramp rate stage: scales the ramp offset, rounds, adds the anchor and clamps.
`default_nettype none

module pfm_scale (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire pfm_pkg::cut_tok_t       tok,
	input  wire logic [pfm_pkg::FC_W-1:0] frame_count,
	output logic                         done,
	output pfm_pkg::result_t             result
);

	logic [pfm_pkg::SPEED_W-1:0]    mag;
	logic [pfm_pkg::PROD_W:0]       rnd;
	logic [pfm_pkg::SUM_W-1:0]      addend;
	logic [pfm_pkg::FC_W-1:0]       fc_dec;

	logic                           vld_s1, vld_s2, vld_s3, vld_s4;
	logic                           hit_s1, hit_s2, hit_s3;
	logic                           neg_s1, neg_s2;
	logic                           sat_s1, sat_s2, sat_s3;
	logic [pfm_pkg::INDEX_BITS-1:0] anchor_s1, anchor_s2;
	logic [pfm_pkg::PROD_W-1:0]     prod_s1;
	logic [pfm_pkg::Q_W-1:0]        q_s2;
	logic [pfm_pkg::SUM_W-1:0]      sum_s3;
	logic [pfm_pkg::INDEX_BITS-1:0] hi_s3;
	pfm_pkg::result_t               res_s4;

	// Magnitude of the signed rate; the most negative rate keeps its bit pattern
	assign mag    = tok.rs[pfm_pkg::SPEED_W-1] ? (~tok.rs + 1'b1) : tok.rs;
	assign rnd    = {1'b0, prod_s1} + pfm_pkg::ROUND_HALF;
	assign addend = hit_s2 ? pfm_pkg::SUM_W'(q_s2) : '0;
	assign fc_dec = (frame_count == '0) ? '0 : (frame_count - 1'b1);

	// Control flags of each stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= tok.vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	// Multiply, round half away from zero, offset the anchor, clamp
	always_ff @(posedge clk) begin
		hit_s1    <= tok.hit;
		neg_s1    <= tok.rs[pfm_pkg::SPEED_W-1];
		sat_s1    <= tok.sat;
		anchor_s1 <= tok.src;
		prod_s1   <= pfm_pkg::PROD_W'(tok.delta) * pfm_pkg::PROD_W'(mag);

		hit_s2    <= hit_s1;
		neg_s2    <= neg_s1;
		sat_s2    <= sat_s1;
		anchor_s2 <= anchor_s1;
		q_s2      <= rnd[pfm_pkg::PROD_W:pfm_pkg::FRAC_BITS];

		hit_s3    <= hit_s2;
		sat_s3    <= sat_s2;
		// upper bound limited to the index maximum
		hi_s3     <= fc_dec[pfm_pkg::INDEX_BITS] ? '1 : fc_dec[pfm_pkg::INDEX_BITS-1:0];
		sum_s3    <= neg_s2 ? (pfm_pkg::SUM_W'(anchor_s2) - addend) :
			(pfm_pkg::SUM_W'(anchor_s2) + addend);

		res_s4.ramp_applied <= hit_s3;
		if (hit_s3 && sum_s3[pfm_pkg::SUM_W-1]) begin
			res_s4.source_index  <= '0;
			res_s4.range_clamped <= 1'b1;
		end else if (hit_s3 && (sum_s3 > pfm_pkg::SUM_W'(hi_s3))) begin
			res_s4.source_index  <= hi_s3;
			res_s4.range_clamped <= 1'b1;
		end else begin
			res_s4.source_index  <= sum_s3[pfm_pkg::INDEX_BITS-1:0];
			res_s4.range_clamped <= sat_s3;
		end
	end

	assign done   = vld_s4;
	assign result = res_s4;

endmodule

`default_nettype wire

@@ rtl/playback_to_source_frame_map_top.sv @@
// Top level of the playback to source frame map: registers, cell chains and rate stage.
// A query token passes the head register, 16 ramp cells, 16 cut cells and 4 rate stages;
// a table write answers with an all-zero result next cycle. Busy falls in the result
// cycle, so a new query waits for the last result; writes go one per cycle when idle.
// The token walks one cell per cycle, so the chain lengths set the query time.
// Reset: frame_count 1, both entry counts 0, pipeline emptied; table contents undefined.
`default_nettype none

module playback_to_source_frame_map_top (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	output logic                                 busy,
	input  wire pfm_pkg::request_t               request,
	output logic                                 done,
	output pfm_pkg::result_t                     result,
	input  wire logic                            cfg_we,
	input  wire logic [pfm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [pfm_pkg::FC_W-1:0]        cfg_data
);

	logic                        take;
	logic                        busy_q;
	logic                        wr_done_q;
	logic [pfm_pkg::FC_W-1:0]    fc_q;
	logic [pfm_pkg::CNT_W-1:0]   cut_cnt_q;
	logic [pfm_pkg::CNT_W-1:0]   ramp_cnt_q;
	pfm_pkg::ramp_tok_t          ramp_head_q;
	pfm_pkg::ent_wr_t            wr_entry;
	pfm_pkg::cut_tok_t           cut_head;
	pfm_pkg::ramp_tok_t          ramp_tok [pfm_pkg::MAX_RAMPS+1];
	pfm_pkg::cut_tok_t           cut_tok  [pfm_pkg::MAX_CUTS+1];
	logic                        q_done;
	pfm_pkg::result_t            q_res;

	assign take = start && !busy;
	assign busy = busy_q && !done;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fc_q       <= pfm_pkg::FC_W'(1);
			cut_cnt_q  <= '0;
			ramp_cnt_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				pfm_pkg::CFG_FRAME_COUNT:  fc_q       <= cfg_data;
				pfm_pkg::CFG_CUT_ENTRIES:  cut_cnt_q  <= cfg_data[pfm_pkg::CNT_W-1:0];
				pfm_pkg::CFG_RAMP_ENTRIES: ramp_cnt_q <= cfg_data[pfm_pkg::CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Track the request in flight and launch query tokens
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			wr_done_q   <= 1'b0;
			ramp_head_q <= '0;
		end else begin
			if (take) begin
				busy_q <= 1'b1;
			end else if (done) begin
				busy_q <= 1'b0;
			end
			wr_done_q       <= take && (request.opcode != pfm_pkg::OP_QUERY);
			ramp_head_q.vld <= take && (request.opcode == pfm_pkg::OP_QUERY);
			ramp_head_q.live <= 1'b1;
			ramp_head_q.hit  <= 1'b0;
			ramp_head_q.p    <= request.playback_index;
			ramp_head_q.rf   <= '0;
			ramp_head_q.rs   <= '0;
		end
	end

	assign wr_entry.first = request.range_first;
	assign wr_entry.after = request.range_after;
	assign wr_entry.speed = request.ramp_speed;

	assign ramp_tok[0] = ramp_head_q;

	// Ramp chain
	for (genvar i = 0; i < pfm_pkg::MAX_RAMPS; i++) begin : g_ramp
		logic wr_sel;
		logic on;
		assign wr_sel = take && (request.opcode == pfm_pkg::OP_RAMP) &&
			(int'(request.entry_slot) == i);
		assign on     = int'(ramp_cnt_q) > i;
		pfm_ramp_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.wr_en    (wr_sel),
			.wr_entry (wr_entry),
			.entry_on (on),
			.tok_in   (ramp_tok[i]),
			.tok_q    (ramp_tok[i+1])
		);
	end

	// Start the cut walk at the ramp start when a ramp was taken, else at the index
	always_comb begin
		cut_head.vld   = ramp_tok[pfm_pkg::MAX_RAMPS].vld;
		cut_head.live  = 1'b1;
		cut_head.sat   = 1'b0;
		cut_head.hit   = ramp_tok[pfm_pkg::MAX_RAMPS].hit;
		cut_head.src   = ramp_tok[pfm_pkg::MAX_RAMPS].hit ? ramp_tok[pfm_pkg::MAX_RAMPS].rf :
			ramp_tok[pfm_pkg::MAX_RAMPS].p;
		cut_head.delta = ramp_tok[pfm_pkg::MAX_RAMPS].p - ramp_tok[pfm_pkg::MAX_RAMPS].rf;
		cut_head.rs    = ramp_tok[pfm_pkg::MAX_RAMPS].rs;
	end

	assign cut_tok[0] = cut_head;

	// Cut chain
	for (genvar i = 0; i < pfm_pkg::MAX_CUTS; i++) begin : g_cut
		logic wr_sel;
		logic on;
		assign wr_sel = take && (request.opcode == pfm_pkg::OP_CUT) &&
			(int'(request.entry_slot) == i);
		assign on     = int'(cut_cnt_q) > i;
		pfm_cut_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.wr_en    (wr_sel),
			.wr_entry (wr_entry),
			.entry_on (on),
			.tok_in   (cut_tok[i]),
			.tok_q    (cut_tok[i+1])
		);
	end

	pfm_scale u_scale (
		.clk         (clk),
		.arst_n      (arst_n),
		.tok         (cut_tok[pfm_pkg::MAX_CUTS]),
		.frame_count (fc_q),
		.done        (q_done),
		.result      (q_res)
	);

	// Merge query results and write acknowledgements
	assign done   = q_done || wr_done_q;
	assign result = q_done ? q_res : '0;

endmodule

`default_nettype wire
